[rtl/sas_pkg.sv]
// Shared constants and codes for the stop-and-wait sender.
`timescale 1ns / 1ps

package sas_pkg;

   localparam int MaxPayloadBytes = 8;
   localparam logic [3:0] PayloadBytesReset = 4'd8;
   localparam logic [15:0] RetransmitReset = 16'd2500;

   // opcodes of an input word
   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_END = 2'd1;
   localparam logic [1:0] OP_ACK = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_EOT = 2'd1;
   localparam logic [1:0] KIND_BUSY = 2'd2;

   // register indexes
   localparam logic CSR_PAYLOAD_BYTES = 1'b0;
   localparam logic CSR_RETRANSMIT = 1'b1;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_STAR = 8'h2A;

endpackage

[rtl/sas_store.sv]
// Frame payload store: one write port, one registered read port.
`timescale 1ns / 1ps

module sas_store #(
   parameter int MAX_PAYLOAD_BYTES = sas_pkg::MaxPayloadBytes,
   localparam int IW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_idx,
   input  logic [7:0]    wr_data,
   input  logic [IW-1:0] rd_idx,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [MAX_PAYLOAD_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sas_ctrl.sv]
// Sequencer: protocol state, retransmit timer and byte-at-a-time frame output.
`timescale 1ns / 1ps

module sas_ctrl #(
   parameter int MAX_PAYLOAD_BYTES = sas_pkg::MaxPayloadBytes,
   localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 1),
   localparam int IW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] frame_len,
   input  logic [15:0]   limit,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_opcode,
   input  logic [7:0]    req_data_byte,
   input  logic [7:0]    req_ack_byte,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic [1:0]    rsp_out_kind,
   output logic          rsp_last_of_run,
   output logic          rsp_is_resend,
   output logic          st_wr_en,
   output logic [IW-1:0] st_wr_idx,
   output logic [7:0]    st_wr_data,
   output logic [IW-1:0] st_rd_idx,
   input  logic [7:0]    st_rd_data
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SEND = 1'b1;
   localparam logic [CW-1:0] MaxFill = CW'(MAX_PAYLOAD_BYTES);

   logic          state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic          resend_ff, resend_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          seq_ff, seq_in;
   logic          await_ff, await_in;
   logic          endp_ff, endp_in;
   logic [15:0]   tick_ff, tick_in;
   logic          ovalid_ff, ovalid_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic [1:0]    okind_ff, okind_in;
   logic          olast_ff, olast_in;
   logic          oresend_ff, oresend_in;

   logic          accept;
   logic          slot_free;
   logic [CW-1:0] fill_inc;
   logic [15:0]   tick_inc;
   logic          ack_good;
   logic [7:0]    emit_byte;
   logic          emit_last;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign slot_free = !ovalid_ff || !rsp_stall;
   assign fill_inc  = fill_ff + 1'b1;
   assign tick_inc  = tick_ff + 16'd1;
   assign ack_good  = ((req_ack_byte == sas_pkg::CH_ZERO) || (req_ack_byte == sas_pkg::CH_ONE))
                      && (req_ack_byte[0] != seq_ff);

   assign st_wr_en   = accept && (req_opcode == sas_pkg::OP_DATA) && !await_ff
                       && (fill_ff < MaxFill);
   assign st_wr_idx  = fill_ff[IW-1:0];
   assign st_wr_data = req_data_byte;
   // store read is registered: fetch the byte for the next emit step
   assign st_rd_idx  = IW'(emit_in - 1'b1);

   // byte for the current emit step
   always_comb begin
      emit_byte = 8'd0;
      emit_last = 1'b1;
      case (mode_ff)
         sas_pkg::KIND_FRAME: begin
            if (emit_ff == '0) begin
               emit_byte = seq_ff ? sas_pkg::CH_ONE : sas_pkg::CH_ZERO;
               emit_last = (fill_ff == '0);
            end else begin
               emit_byte = st_rd_data;
               emit_last = (emit_ff == fill_ff);
            end
         end
         sas_pkg::KIND_EOT: begin
            emit_byte = sas_pkg::CH_STAR;
         end
         default: begin
            emit_byte = 8'd0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      resend_in  = resend_ff;
      emit_in    = emit_ff;
      fill_in    = fill_ff;
      seq_in     = seq_ff;
      await_in   = await_ff;
      endp_in    = endp_ff;
      tick_in    = tick_ff;
      ovalid_in  = ovalid_ff;
      obyte_in   = obyte_ff;
      okind_in   = okind_ff;
      olast_in   = olast_ff;
      oresend_in = oresend_ff;

      if (slot_free) begin
         ovalid_in = 1'b0;
      end

      if (accept) begin
         emit_in = '0;
         case (req_opcode)
            sas_pkg::OP_DATA: begin
               if (await_ff) begin
                  state_in = S_SEND;
                  mode_in  = sas_pkg::KIND_BUSY;
               end else begin
                  fill_in = fill_inc;
                  if (fill_inc >= frame_len) begin
                     state_in  = S_SEND;
                     mode_in   = sas_pkg::KIND_FRAME;
                     resend_in = 1'b0;
                     await_in  = 1'b1;
                     tick_in   = 16'd0;
                  end
               end
            end
            sas_pkg::OP_END: begin
               if (await_ff) begin
                  if (endp_ff) begin
                     state_in = S_SEND;
                     mode_in  = sas_pkg::KIND_BUSY;
                  end else begin
                     endp_in = 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  state_in = S_SEND;
                  mode_in  = sas_pkg::KIND_EOT;
                  seq_in   = 1'b0;
                  endp_in  = 1'b0;
               end else begin
                  endp_in   = 1'b1;
                  state_in  = S_SEND;
                  mode_in   = sas_pkg::KIND_FRAME;
                  resend_in = 1'b0;
                  await_in  = 1'b1;
                  tick_in   = 16'd0;
               end
            end
            sas_pkg::OP_ACK: begin
               if (await_ff) begin
                  if (ack_good) begin
                     fill_in  = '0;
                     await_in = 1'b0;
                     tick_in  = 16'd0;
                     seq_in   = !seq_ff;
                     if (endp_ff) begin
                        // toggle then return to zero after '*'
                        seq_in   = 1'b0;
                        endp_in  = 1'b0;
                        state_in = S_SEND;
                        mode_in  = sas_pkg::KIND_EOT;
                     end
                  end else begin
                     state_in  = S_SEND;
                     mode_in   = sas_pkg::KIND_FRAME;
                     resend_in = 1'b1;
                     tick_in   = 16'd0;
                  end
               end
            end
            default: begin
               if (await_ff) begin
                  if (tick_inc >= limit) begin
                     state_in  = S_SEND;
                     mode_in   = sas_pkg::KIND_FRAME;
                     resend_in = 1'b1;
                     tick_in   = 16'd0;
                  end else begin
                     tick_in = tick_inc;
                  end
               end
            end
         endcase
      end else if (state_ff == S_SEND && slot_free) begin
         ovalid_in  = 1'b1;
         obyte_in   = emit_byte;
         okind_in   = mode_ff;
         olast_in   = emit_last;
         oresend_in = (mode_ff == sas_pkg::KIND_FRAME) && resend_ff;
         emit_in    = emit_ff + 1'b1;
         if (emit_last) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= sas_pkg::KIND_FRAME;
         resend_ff <= 1'b0;
         emit_ff   <= '0;
         fill_ff   <= '0;
         seq_ff    <= 1'b0;
         await_ff  <= 1'b0;
         endp_ff   <= 1'b0;
         tick_ff   <= 16'd0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         resend_ff <= resend_in;
         emit_ff   <= emit_in;
         fill_ff   <= fill_in;
         seq_ff    <= seq_in;
         await_ff  <= await_in;
         endp_ff   <= endp_in;
         tick_ff   <= tick_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      obyte_ff   <= obyte_in;
      okind_ff   <= okind_in;
      olast_ff   <= olast_in;
      oresend_ff <= oresend_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = ovalid_ff;
   assign rsp_out_byte    = obyte_ff;
   assign rsp_out_kind    = okind_ff;
   assign rsp_last_of_run = olast_ff;
   assign rsp_is_resend   = oresend_ff;

endmodule

[rtl/stop_and_wait_arq_sender_top.sv]
// Top level of the alternating-bit stop-and-wait sender.
//
// Input words (req_*) carry an opcode: data byte, end of message, ACK
// byte arrived, or timer tick. Result words (rsp_*) carry link bytes:
// the sequence character and payload of a frame, the '*' end marker,
// or a busy mark for a refused input word. rsp_last_of_run flags the
// final result word caused by one input word.
// A word that gives results is accepted first; then the sequencer
// emits one byte a cycle, unless rsp_stall holds it, out of the frame
// store into the output register. req_stall is high while bytes remain.
// A stall on rsp_stall holds the output register and the sequencer.
// Reset (synchronous) clears the sequence bit, fill count, timer and
// pending state; registers return to 8 payload bytes and 2500 ticks.
// csr_* writes take effect at once; make them only while the block is idle.
`timescale 1ns / 1ps

module stop_and_wait_arq_sender_top #(
   parameter int MAX_PAYLOAD_BYTES = sas_pkg::MaxPayloadBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_ack_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_out_kind,
   output logic        rsp_last_of_run,
   output logic        rsp_is_resend
);

   localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam int IW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

   logic [3:0]    payload_ff, payload_in;
   logic [15:0]   interval_ff, interval_in;
   logic [CW-1:0] frame_len;
   logic [15:0]   limit;
   logic          st_wr_en;
   logic [IW-1:0] st_wr_idx;
   logic [7:0]    st_wr_data;
   logic [IW-1:0] st_rd_idx;
   logic [7:0]    st_rd_data;

   always_comb begin
      payload_in  = payload_ff;
      interval_in = interval_ff;
      if (csr_wr_en) begin
         case (csr_index)
            sas_pkg::CSR_PAYLOAD_BYTES: payload_in = csr_wdata[3:0];
            sas_pkg::CSR_RETRANSMIT:    interval_in = csr_wdata;
            default:                    payload_in = payload_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_ff  <= sas_pkg::PayloadBytesReset;
         interval_ff <= sas_pkg::RetransmitReset;
      end else begin
         payload_ff  <= payload_in;
         interval_ff <= interval_in;
      end
   end

   // clamp the frame size to 1..MAX_PAYLOAD_BYTES, interval to at least 1
   always_comb begin
      if (payload_ff == 4'd0) begin
         frame_len = CW'(1);
      end else if (32'(payload_ff) > 32'(MAX_PAYLOAD_BYTES)) begin
         frame_len = CW'(MAX_PAYLOAD_BYTES);
      end else begin
         frame_len = CW'(32'(payload_ff));
      end
   end

   assign limit = (interval_ff == 16'd0) ? 16'd1 : interval_ff;

   sas_store #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_wr_en),
      .wr_idx (st_wr_idx),
      .wr_data(st_wr_data),
      .rd_idx (st_rd_idx),
      .rd_data(st_rd_data)
   );

   sas_ctrl #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .frame_len      (frame_len),
      .limit          (limit),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_ack_byte   (req_ack_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_is_resend  (rsp_is_resend),
      .st_wr_en       (st_wr_en),
      .st_wr_idx      (st_wr_idx),
      .st_wr_data     (st_wr_data),
      .st_rd_idx      (st_rd_idx),
      .st_rd_data     (st_rd_data)
   );

endmodule

[test/arq_sender_checker.sv]
// Checker for the stop-and-wait sender: watches the channels, predicts link bytes, compares.
`timescale 1ns / 1ps

module arq_sender_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_ack_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic [1:0]  rsp_out_kind,
   input  logic        rsp_last_of_run,
   input  logic        rsp_is_resend,
   output int          failures,
   output int          outstanding,
   output int          bytes_checked,
   output int          resends_seen,
   output int          eots_seen,
   output int          refusals_seen,
   output logic        ack_pending,
   output logic        seq_now,
   output logic        eot_armed,
   output logic [3:0]  fill_now
);
   import sas_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
      logic       resend;
   } link_byte_type;

   link_byte_type link_q[$];
   logic [7:0]  held [MaxPayloadBytes];
   int unsigned fill;
   logic        seq_bit;
   logic        waiting;
   logic        end_armed;
   logic [15:0] ticks;
   logic [3:0]  payload_reg;
   logic [15:0] interval_reg;
   int          fail_n = 0;
   int          checked_n = 0;
   int          resend_n = 0;
   int          eot_n = 0;
   int          busy_n = 0;

   function automatic void push_byte(input logic [7:0] data, input logic [1:0] kind,
                                     input logic last, input logic resend);
      link_byte_type b;
      b.data = data;
      b.kind = kind;
      b.last = last;
      b.resend = resend;
      link_q.push_back(b);
   endfunction

   function automatic int unsigned frame_limit();
      if (payload_reg == 4'd0)
         return 1;
      if (payload_reg > MaxPayloadBytes)
         return MaxPayloadBytes;
      return payload_reg;
   endfunction

   function automatic void send_frame(input logic resend);
      int unsigned len;
      int unsigned i;
      len = (fill > MaxPayloadBytes) ? MaxPayloadBytes : fill;
      push_byte(seq_bit ? CH_ONE : CH_ZERO, KIND_FRAME, len == 0, resend);
      for (i = 0; i < len; i++)
         push_byte(held[i], KIND_FRAME, i + 1 == len, resend);
      waiting = 1'b1;
      ticks = 16'd0;
   endfunction

   function automatic void send_eot();
      push_byte(CH_STAR, KIND_EOT, 1'b1, 1'b0);
      seq_bit = 1'b0;
      end_armed = 1'b0;
   endfunction

   function automatic void predict_word(input logic [1:0] op, input logic [7:0] data,
                                        input logic [7:0] ack);
      case (op)
         OP_DATA: begin
            if (waiting) begin
               push_byte(8'd0, KIND_BUSY, 1'b1, 1'b0);
            end else begin
               if (fill < MaxPayloadBytes)
                  held[fill] = data;
               fill++;
               // a shrunken frame size flushes everything held
               if (fill >= frame_limit())
                  send_frame(1'b0);
            end
         end
         OP_END: begin
            if (waiting) begin
               if (end_armed)
                  push_byte(8'd0, KIND_BUSY, 1'b1, 1'b0);
               else
                  end_armed = 1'b1;
            end else if (fill == 0) begin
               send_eot();
            end else begin
               end_armed = 1'b1;
               send_frame(1'b0);
            end
         end
         OP_ACK: begin
            if (waiting) begin
               if ((ack == CH_ZERO || ack == CH_ONE) && ack[0] != seq_bit) begin
                  seq_bit = ~seq_bit;
                  fill = 0;
                  waiting = 1'b0;
                  ticks = 16'd0;
                  if (end_armed)
                     send_eot();
               end else begin
                  send_frame(1'b1);
               end
            end
         end
         default: begin
            if (waiting) begin
               ticks = ticks + 16'd1;
               if (ticks >= ((interval_reg == 16'd0) ? 16'd1 : interval_reg))
                  send_frame(1'b1);
            end
         end
      endcase
   endfunction

   function automatic void check_byte();
      link_byte_type want;
      checked_n++;
      if (rsp_is_resend)
         resend_n++;
      if (rsp_out_kind == KIND_EOT)
         eot_n++;
      if (rsp_out_kind == KIND_BUSY)
         busy_n++;
      if (link_q.size() == 0) begin
         fail_n++;
         if (fail_n <= 10)
            $display("%0t: unexpected link byte %h kind %0d last %b resend %b", $time,
                     rsp_out_byte, rsp_out_kind, rsp_last_of_run, rsp_is_resend);
         return;
      end
      want = link_q.pop_front();
      if (rsp_out_byte !== want.data || rsp_out_kind !== want.kind ||
          rsp_last_of_run !== want.last || rsp_is_resend !== want.resend) begin
         fail_n++;
         if (fail_n <= 10)
            $display("%0t: expected byte %h kind %0d last %b resend %b, got %h %0d %b %b",
                     $time, want.data, want.kind, want.last, want.resend,
                     rsp_out_byte, rsp_out_kind, rsp_last_of_run, rsp_is_resend);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         seq_bit = 1'b0;
         waiting = 1'b0;
         end_armed = 1'b0;
         ticks = 16'd0;
         payload_reg = PayloadBytesReset;
         interval_reg = RetransmitReset;
         link_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_PAYLOAD_BYTES)
               payload_reg = csr_wdata[3:0];
            else
               interval_reg = csr_wdata;
         end
         // input first, so a result taken at the same edge finds its expectation
         if (req_valid && !req_stall)
            predict_word(req_opcode, req_data_byte, req_ack_byte);
         if (rsp_valid && !rsp_stall)
            check_byte();
      end
      failures <= fail_n;
      outstanding <= link_q.size();
      bytes_checked <= checked_n;
      resends_seen <= resend_n;
      eots_seen <= eot_n;
      refusals_seen <= busy_n;
      ack_pending <= waiting;
      seq_now <= seq_bit;
      eot_armed <= end_armed;
      fill_now <= fill[3:0];
   end

endmodule

[test/tb_top.sv]
// Testbench top for the stop-and-wait sender: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import sas_pkg::*;

   localparam int CycleLimit = 1_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [7:0]  req_data_byte;
   logic [7:0]  req_ack_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_out_kind;
   logic        rsp_last_of_run;
   logic        rsp_is_resend;

   int          failures;
   int          outstanding;
   int          bytes_checked;
   int          resends_seen;
   int          eots_seen;
   int          refusals_seen;
   logic        ack_pending;
   logic        seq_now;
   logic        eot_armed;
   logic [3:0]  fill_now;

   int          gap_odds = 0;
   int          stall_odds = 0;
   bit          calm = 1'b0;
   int          words_sent = 0;
   int          settings_count = 0;
   int          cycle_count = 0;

   // what the stimulus believes the sender is doing
   bit          t_wait;
   bit          t_seq;
   bit          t_end;
   int          t_fill;
   int          p_eff = MaxPayloadBytes;

   stop_and_wait_arq_sender_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .req_ack_byte    (req_ack_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_is_resend   (rsp_is_resend)
   );

   arq_sender_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .req_ack_byte    (req_ack_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_is_resend   (rsp_is_resend),
      .failures        (failures),
      .outstanding     (outstanding),
      .bytes_checked   (bytes_checked),
      .resends_seen    (resends_seen),
      .eots_seen       (eots_seen),
      .refusals_seen   (refusals_seen),
      .ack_pending     (ack_pending),
      .seq_now         (seq_now),
      .eot_armed       (eot_armed),
      .fill_now        (fill_now)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d link bytes still due", cycle_count,
                  outstanding);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver side: random stall bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic put_word(input logic [1:0] op, input logic [7:0] data,
                           input logic [7:0] ack);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      req_ack_byte <= ack;
      words_sent++;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // hold off until every predicted byte is out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic resync();
      drain();
      t_wait = ack_pending;
      t_seq = seq_now;
      t_end = eot_armed;
      t_fill = fill_now;
   endtask

   task automatic configure(input logic [3:0] frame_bytes, input logic [15:0] interval);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PAYLOAD_BYTES;
      csr_wdata <= {12'd0, frame_bytes};
      @(posedge clock);
      csr_index <= CSR_RETRANSMIT;
      csr_wdata <= interval;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (frame_bytes == 4'd0)
         p_eff = 1;
      else if (frame_bytes > MaxPayloadBytes)
         p_eff = MaxPayloadBytes;
      else
         p_eff = frame_bytes;
      settings_count++;
   endtask

   // frame is out: disturb it a little, then acknowledge it properly
   task automatic await_ack();
      int n;
      int k;
      logic [7:0] a;
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 5))
            0: put_word(OP_DATA, 8'($urandom), 8'($urandom));
            1: begin
               a = 8'($urandom);
               if (a == CH_ZERO || a == CH_ONE)
                  a = ~a;
               put_word(OP_ACK, 8'($urandom), a);
            end
            2: put_word(OP_ACK, 8'($urandom), t_seq ? CH_ONE : CH_ZERO);
            3: repeat ($urandom_range(1, 6)) put_word(OP_TICK, 8'($urandom), 8'($urandom));
            4: begin
               put_word(OP_END, 8'($urandom), 8'($urandom));
               t_end = 1'b1;
            end
            default: repeat ($urandom_range(1, 12))
               put_word(OP_TICK, 8'($urandom), 8'($urandom));
         endcase
      end
      put_word(OP_ACK, 8'($urandom), t_seq ? CH_ZERO : CH_ONE);
      t_seq = ~t_seq;
      t_fill = 0;
      t_wait = 1'b0;
      if (t_end) begin
         t_seq = 1'b0;
         t_end = 1'b0;
      end
   endtask

   task automatic send_message();
      int n;
      int k;
      n = $urandom_range(0, 2 * p_eff + 1);
      for (k = 0; k < n; k++) begin
         if (t_wait)
            await_ack();
         put_word(OP_DATA, 8'($urandom), 8'($urandom));
         t_fill++;
         if (t_fill >= p_eff)
            t_wait = 1'b1;
      end
      if (t_wait && $urandom_range(0, 1) == 1) begin
         // message ends while its last frame is still unanswered
         put_word(OP_END, 8'($urandom), 8'($urandom));
         t_end = 1'b1;
         await_ack();
      end else begin
         if (t_wait)
            await_ack();
         put_word(OP_END, 8'($urandom), 8'($urandom));
         if (t_fill == 0) begin
            t_seq = 1'b0;
            t_end = 1'b0;
         end else begin
            t_end = 1'b1;
            t_wait = 1'b1;
            await_ack();
         end
      end
   endtask

   task automatic inject_noise();
      int n;
      int k;
      logic [7:0] a;
      n = $urandom_range(4, 12);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 1) == 1)
            a = ($urandom_range(0, 1) == 1) ? CH_ONE : CH_ZERO;
         else
            a = 8'($urandom);
         put_word(2'($urandom), 8'($urandom), a);
      end
      resync();
   endtask

   // leave a partial store behind so the next setting can shrink below it
   task automatic preload_bytes(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         if (!t_wait && t_fill + 1 < p_eff) begin
            put_word(OP_DATA, 8'($urandom), 8'($urandom));
            t_fill++;
         end
      end
   endtask

   task automatic run_phase(input logic [3:0] frame_bytes, input logic [15:0] interval,
                            input int target, input int gaps, input int stalls);
      int mark;
      drain();
      configure(frame_bytes, interval);
      gap_odds = gaps;
      stall_odds = stalls;
      mark = words_sent;
      while (words_sent - mark < target) begin
         if ($urandom_range(0, 4) == 0)
            inject_noise();
         else
            send_message();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_PAYLOAD_BYTES;
      csr_wdata = 16'd0;
      req_valid = 1'b0;
      req_opcode = OP_DATA;
      req_data_byte = 8'd0;
      req_ack_byte = 8'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, with the reset setting of 8 bytes and 2500 ticks
      stall_odds = 6;
      put_word(OP_DATA, 8'h00, 8'hFF);
      put_word(OP_DATA, 8'hFF, 8'h00);
      put_word(OP_END, 8'hA5, 8'h5A);          // partial frame, end armed
      put_word(OP_ACK, 8'h00, 8'h00);          // bad ACK characters resend
      put_word(OP_ACK, 8'hFF, 8'hFF);
      put_word(OP_ACK, 8'h00, CH_ZERO);        // same sequence resends too
      put_word(OP_DATA, 8'h5A, 8'h00);         // refused
      put_word(OP_END, 8'h00, 8'h00);          // second end refused
      put_word(OP_TICK, 8'hFF, 8'hFF);
      put_word(OP_ACK, 8'h00, CH_ONE);         // good ACK, then '*'
      put_word(OP_ACK, 8'h00, CH_ONE);         // ignored while idle
      put_word(OP_TICK, 8'h00, 8'h00);         // ignored while idle
      put_word(OP_END, 8'h00, 8'h00);          // empty message
      put_word(OP_DATA, 8'hFF, 8'h00);
      put_word(OP_DATA, 8'h00, 8'hFF);
      put_word(OP_DATA, 8'h80, 8'h01);
      put_word(OP_DATA, 8'h01, 8'h80);
      put_word(OP_DATA, 8'h7F, 8'hFE);
      put_word(OP_DATA, 8'hFE, 8'h7F);
      put_word(OP_DATA, 8'hAA, 8'h55);
      put_word(OP_DATA, 8'h55, 8'hAA);         // full frame, sequence '0'
      put_word(OP_ACK, 8'h00, CH_ONE);         // sequence goes to '1'
      put_word(OP_DATA, 8'h33, 8'h00);
      put_word(OP_END, 8'h00, 8'h00);          // frame with sequence '1'
      put_word(OP_ACK, 8'h00, CH_ZERO);
      resync();

      // longest interval: a handful of ticks must not resend
      gap_odds = 0;
      stall_odds = 0;
      configure(4'd9, 16'hFFFF);
      put_word(OP_DATA, 8'hC3, 8'h3C);
      put_word(OP_END, 8'h00, 8'h00);
      repeat (12) put_word(OP_TICK, 8'($urandom), 8'($urandom));
      put_word(OP_ACK, 8'h00, CH_ONE);
      resync();

      run_phase(4'd1, 16'd1, 30, 8, 8);
      run_phase(4'd0, 16'd2, 30, 3, 25);
      run_phase(4'd15, 16'd3, 30, 25, 3);
      preload_bytes(5);
      run_phase(4'd3, 16'd0, 30, 0, 8);
      run_phase(4'd5, 16'($urandom_range(1, 8)), 30, 8, 0);
      calm = 1'b1;
      run_phase(4'd8, 16'd4, 30, 0, 0);
      drain();

      $display("%0d input words over %0d register settings, frame sizes 1 to %0d",
               words_sent, settings_count, MaxPayloadBytes);
      $display("%0d link bytes checked: %0d resent, %0d end markers, %0d refusals",
               bytes_checked, resends_seen, eots_seen, refusals_seen);
      if (failures == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
